// ===== design/i104lc_pkg.sv =====
// ----------------------------------------------------------------------------
// i104lc_pkg
// Types and constants shared by the IEC 104 link control modules.
// ----------------------------------------------------------------------------
package i104lc_pkg;

  // Width of a sequence number and its wrap point.
  localparam int unsigned SeqW = 15;
  localparam logic [SeqW-1:0] SeqLast = 15'd32766;

  // Test frame counter width and its ceiling.
  localparam int unsigned TestW = 4;
  localparam logic [TestW-1:0] TestMax = 4'd15;
  localparam logic [TestW-1:0] TestLimitReset = 4'd10;

  // Register map: register index taken from the word address.
  localparam logic RegTestLimit = 1'b0;

  // Event kinds on the input channel.
  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TIMER = 2'd1,
    OP_START = 2'd2
  } op_e;

  // Kinds of frame sent in reply.
  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_S        = 3'd1,
    KIND_STARTACT = 3'd2,
    KIND_STOPACT  = 3'd3,
    KIND_TESTACT  = 3'd4,
    KIND_TESTCON  = 3'd5,
    KIND_INTERRO  = 3'd6
  } send_kind_e;

  // One received event.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ctrl_octet_1;
    logic [7:0] ctrl_octet_2;
    logic [7:0] ctrl_octet_3;
    logic [7:0] ctrl_octet_4;
  } item_t;

  // One result.
  typedef struct packed {
    logic [2:0]      send_kind;
    logic [SeqW-1:0] send_recv_number;
    logic [SeqW-1:0] send_send_number;
    logic            status;
    logic            transfer_active;
  } result_t;

  // Sequence number advance, modulo 32767.
  function automatic logic [SeqW-1:0] seq_next(input logic [SeqW-1:0] v);
    logic [SeqW-1:0] r;
    if (v == SeqLast) begin
      r = '0;
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

endpackage

// ===== design/i104lc_cfg.sv =====
// ----------------------------------------------------------------------------
// i104lc_cfg
// APB register block holding the test frame limit.
// ----------------------------------------------------------------------------
module i104lc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [i104lc_pkg::TestW-1:0]  test_limit_o
);

  logic                         reg_sel;
  logic                         wr_en;
  logic [i104lc_pkg::TestW-1:0] test_limit_q;

  // Word address picks the register; the byte offset is ignored.
  assign reg_sel = (paddr[2] == i104lc_pkg::RegTestLimit);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_limit_q <= i104lc_pkg::TestLimitReset;
    end else if (wr_en && reg_sel) begin
      test_limit_q <= pwdata[i104lc_pkg::TestW-1:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[i104lc_pkg::TestW-1:0] = test_limit_q;
    end
  end

  assign test_limit_o = test_limit_q;

endmodule

// ===== design/i104lc_in_stage.sv =====
// ----------------------------------------------------------------------------
// i104lc_in_stage
// Input register for one event, loaded whenever it is empty or draining.
// ----------------------------------------------------------------------------
module i104lc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i104lc_pkg::item_t item_i,
  input  logic              fwd_ready_i,
  output logic              valid_o,
  output i104lc_pkg::item_t item_o
);

  logic              valid_q;
  logic              load_en;
  i104lc_pkg::item_t item_q;

  // The stage takes a new event when empty or when its event moves on.
  assign load_en    = !valid_q || fwd_ready_i;
  assign in_stall_o = !load_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_en) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_en && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/i104lc_ctrl.sv =====
// ----------------------------------------------------------------------------
// i104lc_ctrl
// Link state and the per-event decision: sequence checks, U frame handling,
// test timer bookkeeping and the reply to send.
// ----------------------------------------------------------------------------
module i104lc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  i104lc_pkg::item_t            item_i,
  input  logic [i104lc_pkg::TestW-1:0] test_limit_i,
  output i104lc_pkg::result_t          result_o
);

  logic                         stopped_q, stopped_d;
  logic                         pending_q, pending_d;
  logic [i104lc_pkg::SeqW-1:0]  recv_q, recv_d;
  logic [i104lc_pkg::SeqW-1:0]  send_q, send_d;
  logic [i104lc_pkg::TestW-1:0] tests_q, tests_d;
  logic [i104lc_pkg::SeqW-1:0]  frame_ns;
  logic [i104lc_pkg::SeqW-1:0]  frame_nr;
  logic [7:0]                   o1;

  // Sequence numbers carried in the control octets.
  assign o1       = item_i.ctrl_octet_1;
  assign frame_ns = {item_i.ctrl_octet_2, item_i.ctrl_octet_1[7:1]};
  assign frame_nr = {item_i.ctrl_octet_4, item_i.ctrl_octet_3[7:1]};

  // Next state and reply for the event in the input register.
  always_comb begin
    stopped_d = stopped_q;
    pending_d = pending_q;
    recv_d    = recv_q;
    send_d    = send_q;
    tests_d   = tests_q;
    result_o  = '0;
    result_o.send_kind = i104lc_pkg::KIND_NONE;
    case (i104lc_pkg::op_e'(item_i.op))
      i104lc_pkg::OP_FRAME: begin
        if (!o1[0]) begin
          // I frame: only in sequence while transfer runs.
          if (stopped_q || (frame_ns != recv_q)) begin
            result_o.status = 1'b1;
          end else begin
            recv_d = i104lc_pkg::seq_next(recv_q);
            result_o.send_kind        = i104lc_pkg::KIND_S;
            result_o.send_recv_number = recv_d;
          end
        end else if (!o1[1]) begin
          // S frame: acknowledge must match the send count.
          if (frame_nr != send_q) begin
            result_o.status = 1'b1;
          end else begin
            send_d = i104lc_pkg::seq_next(send_q);
          end
        end else if (o1[2]) begin
          result_o.status = 1'b1;
        end else if (o1[3]) begin
          // STARTDT confirmed: issue the general interrogation.
          result_o.send_kind        = i104lc_pkg::KIND_INTERRO;
          result_o.send_recv_number = recv_q;
          result_o.send_send_number = send_q;
          send_d    = i104lc_pkg::seq_next(send_q);
          stopped_d = 1'b0;
        end else if (o1[4]) begin
          result_o.status = 1'b1;
        end else if (o1[5]) begin
          stopped_d = 1'b1;
        end else if (o1[6]) begin
          result_o.send_kind = i104lc_pkg::KIND_TESTCON;
          pending_d = 1'b0;
        end else begin
          // TESTCON, also taken when no function bit is set.
          result_o.status = !pending_q;
          pending_d = 1'b0;
        end
      end
      i104lc_pkg::OP_TIMER: begin
        if (tests_q > test_limit_i) begin
          result_o.send_kind = i104lc_pkg::KIND_STOPACT;
        end else begin
          stopped_d = 1'b1;
          if (tests_q != i104lc_pkg::TestMax) begin
            tests_d = tests_q + 4'd1;
          end
          result_o.send_kind = i104lc_pkg::KIND_TESTACT;
        end
      end
      i104lc_pkg::OP_START: begin
        stopped_d = 1'b1;
        result_o.send_kind = i104lc_pkg::KIND_STARTACT;
      end
      default: begin
        result_o.status = 1'b1;
      end
    endcase
    result_o.transfer_active = !stopped_d;
  end

  // State registers advance when the event moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b1;
      pending_q <= 1'b1;
      recv_q    <= '0;
      send_q    <= '0;
      tests_q   <= '0;
    end else if (adv_i) begin
      stopped_q <= stopped_d;
      pending_q <= pending_d;
      recv_q    <= recv_d;
      send_q    <= send_d;
      tests_q   <= tests_d;
    end
  end

  // Counters wrap before the all-ones value.
  a_recv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recv_q != 15'h7FFF)
    else $error("receive count reached the reserved value");

  a_send_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_q != 15'h7FFF)
    else $error("send count reached the reserved value");

  // State moves only when an event is consumed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(recv_q) && $stable(send_q) && $stable(stopped_q))
    else $error("link state changed without an event");

  // An interrogation always starts data transfer.
  a_interro_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.send_kind == i104lc_pkg::KIND_INTERRO) |-> result_o.transfer_active)
    else $error("interrogation sent while transfer stopped");

endmodule

// ===== design/iec104_link_control_top.sv =====
// ----------------------------------------------------------------------------
// iec104_link_control_top
// Master-side IEC 60870-5-104 APCI link control.
// ----------------------------------------------------------------------------
// The input channel carries one event per item: a received frame's four
// control octets, a test timer expiry or a start request. The output channel
// returns exactly one result per event: the kind of frame to send, its
// sequence numbers, an accept/reject status and the transfer flag.
// Both channels use valid and stall; an item moves at a clock edge with valid
// high and stall low. The APB port holds the test frame limit.
// An event is registered on acceptance, decided from the input register and
// written into the result register once that register can take it. One
// event per cycle is sustained while the output does not stall: the input
// register and the result register are the only stages, and the link state
// is updated as each event passes between them.
// A stall on the output holds the result register; the input register then
// keeps its event and stalls the input only while both stages are full.
// Reset stops data transfer, sets test pending, clears both sequence counters
// and the test count, and sets the test limit to ten.
// ----------------------------------------------------------------------------
module iec104_link_control_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  ctrl_octet_1_i,
  input  logic [7:0]  ctrl_octet_2_i,
  input  logic [7:0]  ctrl_octet_3_i,
  input  logic [7:0]  ctrl_octet_4_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  send_kind_o,
  output logic [14:0] send_recv_number_o,
  output logic [14:0] send_send_number_o,
  output logic        status_o,
  output logic        transfer_active_o
);

  logic                         out_ready;
  logic                         stage_valid;
  logic                         adv;
  logic                         out_valid_q;
  logic [i104lc_pkg::TestW-1:0] test_limit;
  i104lc_pkg::item_t            in_item;
  i104lc_pkg::item_t            stage_item;
  i104lc_pkg::result_t          result;
  i104lc_pkg::result_t          result_q;

  // Configuration registers.
  i104lc_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .test_limit_o (test_limit)
  );

  // Input register.
  assign in_item.op           = op_i;
  assign in_item.ctrl_octet_1 = ctrl_octet_1_i;
  assign in_item.ctrl_octet_2 = ctrl_octet_2_i;
  assign in_item.ctrl_octet_3 = ctrl_octet_3_i;
  assign in_item.ctrl_octet_4 = ctrl_octet_4_i;

  i104lc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .fwd_ready_i (out_ready),
    .valid_o     (stage_valid),
    .item_o      (stage_item)
  );

  // The result register takes a value when empty or being drained.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign adv       = stage_valid && out_ready;

  // Decision logic and link state.
  i104lc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (stage_item),
    .test_limit_i (test_limit),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign send_kind_o        = result_q.send_kind;
  assign send_recv_number_o = result_q.send_recv_number;
  assign send_send_number_o = result_q.send_send_number;
  assign status_o           = result_q.status;
  assign transfer_active_o  = result_q.transfer_active;

  // The input stalls only while both stages hold an event.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage_valid && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // A consumed event always yields a valid result on the next cycle.
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("event consumed without a result");

  // A held result keeps its value.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(result_q))
    else $error("stalled result changed");

endmodule
